/* rtl/csq_pkg.sv */
// Package for the cursor sequence store: sizes, request/result types and codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package csq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Opcodes
    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_ADVANCE = 3'd2;
    localparam logic [2:0] OP_INSERT  = 3'd3;
    localparam logic [2:0] OP_ATTACH  = 3'd4;
    localparam logic [2:0] OP_REMOVE  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NO_CURRENT = 2'd2;

    // Stack commands; LOAD rewrites the top cell only
    typedef logic [1:0] stack_cmd_t;
    localparam stack_cmd_t SCMD_HOLD = 2'd0;
    localparam stack_cmd_t SCMD_PUSH = 2'd1;
    localparam stack_cmd_t SCMD_POP  = 2'd2;
    localparam stack_cmd_t SCMD_LOAD = 2'd3;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [DATA_WIDTH-1:0] entry_value;
    } csq_req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] current_value;
        logic                  has_current;
        logic [CNT_W-1:0]      item_count;
        logic [1:0]            status;
    } csq_rsp_t;

endpackage

`default_nettype wire

/* rtl/csq_cell.sv */
// One storage cell of a stack chain: holds one entry, shifts with its neighbors.
// Depends on csq_pkg.
`default_nettype none

module csq_cell
    import csq_pkg::*;
(
    input  wire logic                  clk,
    input  wire stack_cmd_t            cmd,
    input  wire logic [DATA_WIDTH-1:0] up_in,
    input  wire logic [DATA_WIDTH-1:0] down_in,
    output logic      [DATA_WIDTH-1:0] value
);

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;

    always_comb
    begin
        case (cmd)
            SCMD_PUSH: value_next = up_in;
            SCMD_POP:  value_next = down_in;
            default:   value_next = value_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

/* rtl/csq_stack.sv */
// A stack built as a chain of csq_cell; cell 0 is the top.
// Depends on csq_pkg and csq_cell.
`default_nettype none

module csq_stack
    import csq_pkg::*;
(
    input  wire logic                  clk,
    input  wire stack_cmd_t            cmd,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    output logic      [DATA_WIDTH-1:0] top_data
);

    logic [DATA_WIDTH-1:0] cell_val [DEPTH];
    stack_cmd_t            top_cmd;
    stack_cmd_t            body_cmd;

    // LOAD: only the top cell takes the new value
    assign top_cmd  = (cmd == SCMD_LOAD) ? SCMD_PUSH : cmd;
    assign body_cmd = (cmd == SCMD_LOAD) ? SCMD_HOLD : cmd;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] up_val;
        logic [DATA_WIDTH-1:0] down_val;

        if (i == 0)
        begin : g_top
            assign up_val = push_data;
        end
        else
        begin : g_mid
            assign up_val = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign down_val = cell_val[i];
        end
        else
        begin : g_inner
            assign down_val = cell_val[i+1];
        end

        csq_cell u_cell (
            .clk     (clk),
            .cmd     ((i == 0) ? top_cmd : body_cmd),
            .up_in   (up_val),
            .down_in (down_val),
            .value   (cell_val[i])
        );
    end

    assign top_data = cell_val[0];

endmodule

`default_nettype wire

/* rtl/cursor_sequence_store.sv */
// Cursor sequence store, top level: two cell-chain stacks forming a gap buffer.
// Depends on csq_pkg, csq_stack (and through it csq_cell).
//
//  channel   handshake              payload      direction
//  request   start / busy           request      in   (taken when start && !busy)
//  result    done (one-cycle strobe) result      out  (cannot be held off)
//
// Cycles: done and the result show in the cycle after the request is taken,
// except for start with items before the cursor and insert with no current
// item into a non-empty store: these rewind the cursor to the front one entry
// per cycle, replay the held request once the left stack is empty, then raise
// done. busy is high while the store rewinds and replays, until done.
// Reset: the store is empty, no current item. Stored entries are not reset.
// The receiver cannot stall; results are never held.
`default_nettype none

module cursor_sequence_store
    import csq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire csq_req_t request,
    output logic          done,
    output csq_rsp_t      result
);

    // The sequence is split at the cursor: the left stack holds the items before
    // the cursor (top = the one just before it), the right stack holds the
    // current item and everything after (top = current item). The current item
    // is always at a fixed cell, right stack cell 0.

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REWIND = 1'b1;

    logic                  state_reg, state_next;
    logic [CNT_W-1:0]      left_cnt_reg, left_cnt_next;
    logic [CNT_W-1:0]      right_cnt_reg, right_cnt_next;
    logic [2:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;

    stack_cmd_t            left_cmd, right_cmd;
    logic [DATA_WIDTH-1:0] left_top, right_top, right_push;

    logic [2:0]            eff_op;
    logic [DATA_WIDTH-1:0] eff_entry;
    logic [CNT_W-1:0]      total_cnt;
    logic                  full;
    logic                  go;
    logic                  rewind_step;
    logic                  need_rewind;

    csq_stack u_left (
        .clk       (clk),
        .cmd       (left_cmd),
        .push_data (right_top),
        .top_data  (left_top)
    );

    csq_stack u_right (
        .clk       (clk),
        .cmd       (right_cmd),
        .push_data (right_push),
        .top_data  (right_top)
    );

    // Held request replays once the rewind has emptied the left stack
    assign eff_op    = (state_reg == ST_REWIND) ? op_reg : request.opcode;
    assign eff_entry = (state_reg == ST_REWIND) ? entry_reg : request.entry_value;

    assign total_cnt   = left_cnt_reg + right_cnt_reg;
    assign full        = (total_cnt == CNT_W'(DEPTH));
    assign go          = ((state_reg == ST_IDLE) && start)
                      || ((state_reg == ST_REWIND) && (left_cnt_reg == '0));
    assign rewind_step = (state_reg == ST_REWIND) && (left_cnt_reg != '0);

    always_comb
    begin
        left_cmd       = SCMD_HOLD;
        right_cmd      = SCMD_HOLD;
        right_push     = eff_entry;
        left_cnt_next  = left_cnt_reg;
        right_cnt_next = right_cnt_reg;
        status_next    = status_reg;
        need_rewind    = 1'b0;

        if (rewind_step)
        begin
            // move one entry from the left top onto the right stack
            left_cmd       = SCMD_POP;
            right_cmd      = SCMD_PUSH;
            right_push     = left_top;
            left_cnt_next  = left_cnt_reg - CNT_W'(1);
            right_cnt_next = right_cnt_reg + CNT_W'(1);
        end
        else if (go)
        begin
            status_next = ST_OK;
            case (eff_op)
                OP_START:
                begin
                    if (left_cnt_reg != '0)
                    begin
                        need_rewind = 1'b1;
                    end
                end
                OP_ADVANCE:
                begin
                    if (right_cnt_reg == '0)
                    begin
                        status_next = ST_NO_CURRENT;
                    end
                    else
                    begin
                        left_cmd       = SCMD_PUSH;
                        right_cmd      = SCMD_POP;
                        left_cnt_next  = left_cnt_reg + CNT_W'(1);
                        right_cnt_next = right_cnt_reg - CNT_W'(1);
                    end
                end
                OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if ((right_cnt_reg == '0) && (left_cnt_reg != '0))
                    begin
                        // no current item: goes to the front
                        need_rewind = 1'b1;
                    end
                    else
                    begin
                        right_cmd      = SCMD_PUSH;
                        right_cnt_next = right_cnt_reg + CNT_W'(1);
                    end
                end
                OP_ATTACH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (right_cnt_reg != '0)
                    begin
                        // current moves left, new entry replaces it on top
                        left_cmd      = SCMD_PUSH;
                        right_cmd     = SCMD_LOAD;
                        left_cnt_next = left_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // cursor at end: append
                        right_cmd      = SCMD_PUSH;
                        right_cnt_next = right_cnt_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (right_cnt_reg == '0)
                    begin
                        status_next = ST_NO_CURRENT;
                    end
                    else
                    begin
                        right_cmd      = SCMD_POP;
                        right_cnt_next = right_cnt_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        entry_next = entry_reg;
        done_next  = go && !need_rewind;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.opcode;
                    entry_next = request.entry_value;
                    if (need_rewind)
                    begin
                        state_next = ST_REWIND;
                    end
                end
            end
            ST_REWIND:
            begin
                if (left_cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        entry_reg <= entry_next;
    end

    // Result fields come straight from the updated state registers
    assign busy                 = (state_reg == ST_REWIND);
    assign done                 = done_reg;
    assign result.has_current   = (right_cnt_reg != '0);
    assign result.current_value = (right_cnt_reg != '0) ? right_top : '0;
    assign result.item_count    = total_cnt;
    assign result.status        = status_reg;

endmodule

`default_nettype wire

/* rtl/csq_checker.sv */
// Port-level checks for cursor_sequence_store, bound to the top level.
// Depends on csq_pkg and cursor_sequence_store.
`default_nettype none

module csq_checker
    import csq_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire csq_rsp_t result
);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.item_count <= CNT_W'(DEPTH)))
        else $error("item_count above DEPTH");

    a_no_current_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_current) |-> (result.current_value == '0))
        else $error("current_value nonzero with no current item");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.item_count == CNT_W'(DEPTH)))
        else $error("full status with store not full");

    a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request neither answered nor rewinding");

    a_rewind_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("rewind ended without a result");

endmodule

bind cursor_sequence_store csq_checker u_csq_checker (.*);

`default_nettype wire
